// File: hw/rtl/ilir_pkg.sv
package ilir_pkg;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 6;
    localparam int IN_WORD_W  = 32;
    localparam int OUT_WORD_W = 32;
    localparam int CNT_W      = 5;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_FETCH,
        S_FETCH_WAIT,
        S_DEL_RD,
        S_DEL_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic ins_rd;
        logic ins_wr;
        logic put_word;
        logic fetch;
        logic capture;
        logic del_rd;
        logic del_wr;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic acc_ok;
        logic acc_fill;
        logic ins_more;
        logic del_more;
        logic is_remove;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/ilir_if.sv
interface ilir_in_if;
    import ilir_pkg::*;

    logic                        valid;
    logic                        ready;
    t_cmd                        cmd;
    logic signed [POS_W-1:0]     position;
    logic        [IN_WORD_W-1:0] item_value;

    modport source (output valid, output cmd, output position, output item_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input item_value,
                    output ready);
endinterface

interface ilir_out_if;
    import ilir_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OUT_WORD_W-1:0] read_value;
    logic [CNT_W-1:0]      count;
    t_status               status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

// File: hw/rtl/indexed_list_insert_remove.sv
// channel | dir | fields                        | handshake
// i_in    | in  | cmd, position, item_value     | valid/ready
// o_out   | out | read_value, count, status     | valid/ready
//
// one item at a time: read fetches its entry, append or insert moves entries up
// then writes the word, remove fetches then moves entries down, failed command
// goes to the result; moves use the entry ram, one read then one write per entry
// reset clears the count and the output valid flag; entries need no clearing
// a result waits in the output register while the next item is taken
module indexed_list_insert_remove #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    ilir_in_if.sink    i_in,
    ilir_out_if.source o_out
);
    import ilir_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    ilir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    ilir_dp #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctrl_cmd),
        .o_stat       (dp_stat),
        .i_op         (i_in.cmd),
        .i_position   (i_in.position),
        .i_item_value (i_in.item_value),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_read_value (o_out.read_value),
        .o_count      (o_out.count),
        .o_status     (o_out.status)
    );
endmodule

// File: hw/rtl/ilir_ram.sv
module ilir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: hw/rtl/ilir_ctrl.sv
module ilir_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ilir_pkg::t_dp_stat  i_stat,
    output ilir_pkg::t_ctrl_cmd o_cmd
);
    import ilir_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.acc_ok) begin
                        n_state = S_FINISH;
                    end else if (i_stat.acc_fill) begin
                        n_state = S_INS_RD;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_INS_RD: begin
                if (i_stat.ins_more) begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_WR;
                end else begin
                    o_cmd.put_word = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_INS_RD;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_FETCH_WAIT;
            end
            S_FETCH_WAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = i_stat.is_remove ? S_DEL_RD : S_FINISH;
            end
            S_DEL_RD: begin
                if (i_stat.del_more) begin
                    o_cmd.del_rd = 1'b1;
                    n_state      = S_DEL_WR;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DEL_WR: begin
                o_cmd.del_wr = 1'b1;
                n_state      = S_DEL_RD;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/ilir_dp.sv
module ilir_dp #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ilir_pkg::t_ctrl_cmd                  i_cmd,
    output ilir_pkg::t_dp_stat                   o_stat,
    input  ilir_pkg::t_cmd                       i_op,
    input  logic signed [ilir_pkg::POS_W-1:0]    i_position,
    input  logic [ilir_pkg::IN_WORD_W-1:0]       i_item_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [ilir_pkg::OUT_WORD_W-1:0]      o_read_value,
    output logic [ilir_pkg::CNT_W-1:0]           o_count,
    output ilir_pkg::t_status                    o_status
);
    import ilir_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    t_cmd                  r_op;
    t_status               r_status;
    logic [AW-1:0]         r_slot;
    logic [AW-1:0]         r_ptr;
    logic [WORD_BITS-1:0]  r_word;
    logic [WORD_BITS-1:0]  r_value;

    logic                  r_out_valid;
    logic [OUT_WORD_W-1:0] r_read_value;
    logic [CNT_W-1:0]      r_out_count;
    t_status               r_out_status;

    logic signed [SW-1:0]  p_ext;
    logic signed [SW-1:0]  cnt_ext;
    logic signed [SW-1:0]  sum_ext;
    logic                  full;
    logic                  empty;
    t_status               acc_status;
    logic [AW-1:0]         acc_slot;
    logic                  acc_fill;
    logic                  op_fill;

    logic [63:0]           word_wide;
    logic [63:0]           value_wide;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [WORD_BITS-1:0]  ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [WORD_BITS-1:0]  ram_rd_data;

    // index checks against the current count
    always_comb begin
        p_ext      = SW'(i_position);
        cnt_ext    = $signed(SW'(r_count));
        sum_ext    = cnt_ext + p_ext;
        full       = (r_count == CW'(CAPACITY));
        empty      = (r_count == '0);
        acc_status = ST_OK;
        acc_slot   = r_count[AW-1:0];
        case (i_op) inside
            CMD_APPEND: begin
                if (full) begin
                    acc_status = ST_FULL;
                end
            end
            CMD_INSERT: begin
                if (p_ext[SW-1] || (p_ext > cnt_ext)) begin
                    acc_status = ST_RANGE;
                end else if (full) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_slot = p_ext[AW-1:0];
                end
            end
            CMD_REMOVE, CMD_READ: begin
                if (empty) begin
                    acc_status = ST_EMPTY;
                end else if ((p_ext >= cnt_ext) || (p_ext < -cnt_ext)) begin
                    acc_status = ST_RANGE;
                end else if (p_ext[SW-1]) begin
                    acc_slot = sum_ext[AW-1:0];
                end else begin
                    acc_slot = p_ext[AW-1:0];
                end
            end
            default: begin
                acc_status = ST_OK;
            end
        endcase
    end

    assign acc_fill   = (i_op == CMD_APPEND) || (i_op == CMD_INSERT);
    assign op_fill    = (r_op == CMD_APPEND) || (r_op == CMD_INSERT);
    assign word_wide  = 64'(i_item_value);
    assign value_wide = 64'(r_value);

    always_comb begin
        n_count = r_count;
        if (i_cmd.finish && (r_status == ST_OK)) begin
            if (op_fill) begin
                n_count = r_count + CW'(1);
            end else if (r_op == CMD_REMOVE) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    assign o_stat.acc_ok    = (acc_status == ST_OK);
    assign o_stat.acc_fill  = acc_fill;
    assign o_stat.ins_more  = (r_ptr != r_slot);
    assign o_stat.del_more  = ((CW'(r_ptr) + CW'(1)) < r_count);
    assign o_stat.is_remove = (r_op == CMD_REMOVE);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // entry moves go through the ram one word per read and write pair
    assign ram_rd_en   = i_cmd.ins_rd || i_cmd.del_rd || i_cmd.fetch;
    assign ram_rd_addr = i_cmd.ins_rd ? (r_ptr - AW'(1)) :
                         i_cmd.del_rd ? (r_ptr + AW'(1)) : r_slot;
    assign ram_wr_en   = i_cmd.ins_wr || i_cmd.del_wr || i_cmd.put_word;
    assign ram_wr_addr = i_cmd.put_word ? r_slot : r_ptr;
    assign ram_wr_data = i_cmd.put_word ? r_word : ram_rd_data;

    ilir_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_status <= acc_status;
            r_slot   <= acc_slot;
            r_ptr    <= acc_fill ? r_count[AW-1:0] : acc_slot;
            r_word   <= word_wide[WORD_BITS-1:0];
            r_value  <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_value <= ram_rd_data;
            end
            if (i_cmd.ins_wr) begin
                r_ptr <= r_ptr - AW'(1);
            end else if (i_cmd.del_wr) begin
                r_ptr <= r_ptr + AW'(1);
            end
        end
        if (i_cmd.finish) begin
            r_read_value <= value_wide[OUT_WORD_W-1:0];
            r_out_count  <= CNT_W'(n_count);
            r_out_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_count      = r_out_count;
    assign o_status     = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_status == ST_OK) && op_fill)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("successful append or insert did not grow the list");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_status != ST_OK)) |=> $stable(r_count))
        else $error("failed command changed the count");

    a_fail_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_OK) && !i_cmd.load |-> !ram_wr_en)
        else $error("failed command wrote an entry");
endmodule
